@@ rtl/core/phr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package phr_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int CH_W       = 12;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int MAX_COLORS = 1024;
    localparam int ONE        = 1 << FRAC_BITS;

    localparam int SECT_BITS = 3;
    localparam int MOD_STEPS = IDX_W;
    localparam int HUE_STEPS = SECT_BITS + FRAC_BITS;
    localparam int REM_W     = CNT_W + 2;
    localparam int PIPE_LAT  = MOD_STEPS + HUE_STEPS + 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_SWING = 3'd3;

    localparam logic [CNT_W-1:0] RST_COLOR_COUNT  = 11'd1;
    localparam logic [CH_W-1:0]  RST_SATURATION   = 12'd3686;
    localparam logic [CH_W-1:0]  RST_BRIGHT_BASE  = 12'd2458;
    localparam logic [CH_W-1:0]  RST_BRIGHT_SWING = 12'd1229;

    localparam logic [SECT_BITS-1:0] SEC_RED_GREEN  = 3'd0;
    localparam logic [SECT_BITS-1:0] SEC_GREEN_RED  = 3'd1;
    localparam logic [SECT_BITS-1:0] SEC_GREEN_BLUE = 3'd2;
    localparam logic [SECT_BITS-1:0] SEC_BLUE_GREEN = 3'd3;
    localparam logic [SECT_BITS-1:0] SEC_BLUE_RED   = 3'd4;

    typedef struct packed {
        logic                 odd;
        logic [SECT_BITS-1:0] sector;
        logic [FRAC_BITS-1:0] frac;
    } t_hue;

endpackage
`default_nettype wire

@@ rtl/core/palette_hsv_to_rgb_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle while busy is low; the 27-stage bit-per-stage divider and the 3 math
// stages each take a new item every cycle
// the receiver cannot stall, so busy drops at the first edge after reset and stays low
// reset: synchronous active low, clears valid bits and loads the register defaults
module palette_hsv_to_rgb_unit
    import phr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [IDX_W-1:0]      i_color_index,
    output logic                       o_strobe,
    output logic [CH_W-1:0]            o_red,
    output logic [CH_W-1:0]            o_green,
    output logic [CH_W-1:0]            o_blue,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CNT_W-1:0] r_count;
    logic [CH_W-1:0]  r_sat;
    logic [CH_W-1:0]  r_base;
    logic [CH_W-1:0]  r_swing;
    logic [CNT_W-1:0] r_n_eff;
    logic             r_busy;

    logic accept;
    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= RST_COLOR_COUNT;
            r_sat   <= RST_SATURATION;
            r_base  <= RST_BRIGHT_BASE;
            r_swing <= RST_BRIGHT_SWING;
            r_busy  <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_COLOR_COUNT:  r_count <= i_cfg_data[CNT_W-1:0];
                    REG_SATURATION:   r_sat   <= i_cfg_data[CH_W-1:0];
                    REG_BRIGHT_BASE:  r_base  <= i_cfg_data[CH_W-1:0];
                    REG_BRIGHT_SWING: r_swing <= i_cfg_data[CH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // clamp palette size to 1..MAX_COLORS
    always_ff @(posedge i_clk) begin
        if (r_count == '0) begin
            r_n_eff <= CNT_W'(1);
        end else if (r_count > CNT_W'(MAX_COLORS)) begin
            r_n_eff <= CNT_W'(MAX_COLORS);
        end else begin
            r_n_eff <= r_count;
        end
    end

    logic div_valid;
    t_hue div_hue;

    phr_hue_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_idx   (i_color_index),
        .i_n     (r_n_eff),
        .o_valid (div_valid),
        .o_hue   (div_hue)
    );

    // brightness per parity
    logic [CH_W:0]   bright_sum;
    logic [CH_W-1:0] v_even;
    logic [CH_W-1:0] v_odd;
    logic [CH_W-1:0] v_sel;
    assign bright_sum = {1'b0, r_base} + {1'b0, r_swing};
    assign v_even     = bright_sum[CH_W] ? {CH_W{1'b1}} : bright_sum[CH_W-1:0];
    assign v_odd      = (r_base >= r_swing) ? r_base - r_swing : '0;
    assign v_sel      = div_hue.odd ? v_odd : v_even;

    logic [FRAC_BITS:0]   one_minus_f;
    logic [FRAC_BITS:0]   one_minus_s;
    logic [2*CH_W-1:0]    prod_sf;
    logic [2*CH_W:0]      prod_sf2;
    logic [2*CH_W:0]      prod_p;
    assign one_minus_f = (FRAC_BITS+1)'(ONE) - {1'b0, div_hue.frac};
    assign one_minus_s = (FRAC_BITS+1)'(ONE) - {1'b0, r_sat};
    assign prod_sf     = r_sat * div_hue.frac;
    assign prod_sf2    = {1'b0, r_sat} * one_minus_f;
    assign prod_p      = {1'b0, v_sel} * one_minus_s;

    logic                 r_a_valid;
    logic [SECT_BITS-1:0] r_a_sector;
    logic [CH_W-1:0]      r_a_v;
    logic [CH_W-1:0]      r_a_sf;
    logic [CH_W-1:0]      r_a_sf2;
    logic [CH_W-1:0]      r_a_p;

    always_ff @(posedge i_clk) begin
        r_a_sector <= div_hue.sector;
        r_a_v      <= v_sel;
        r_a_sf     <= prod_sf[FRAC_BITS +: CH_W];
        r_a_sf2    <= prod_sf2[FRAC_BITS +: CH_W];
        r_a_p      <= prod_p[FRAC_BITS +: CH_W];
    end

    logic [FRAC_BITS:0] one_minus_sf;
    logic [FRAC_BITS:0] one_minus_sf2;
    logic [2*CH_W:0]    prod_q;
    logic [2*CH_W:0]    prod_t;
    assign one_minus_sf  = (FRAC_BITS+1)'(ONE) - {1'b0, r_a_sf};
    assign one_minus_sf2 = (FRAC_BITS+1)'(ONE) - {1'b0, r_a_sf2};
    assign prod_q        = {1'b0, r_a_v} * one_minus_sf;
    assign prod_t        = {1'b0, r_a_v} * one_minus_sf2;

    logic                 r_b_valid;
    logic [SECT_BITS-1:0] r_b_sector;
    logic [CH_W-1:0]      r_b_v;
    logic [CH_W-1:0]      r_b_p;
    logic [CH_W-1:0]      r_b_q;
    logic [CH_W-1:0]      r_b_t;

    always_ff @(posedge i_clk) begin
        r_b_sector <= r_a_sector;
        r_b_v      <= r_a_v;
        r_b_p      <= r_a_p;
        r_b_q      <= prod_q[FRAC_BITS +: CH_W];
        r_b_t      <= prod_t[FRAC_BITS +: CH_W];
    end

    logic [CH_W-1:0] n_red;
    logic [CH_W-1:0] n_green;
    logic [CH_W-1:0] n_blue;

    always_comb begin
        if (r_sat == '0) begin
            n_red   = r_b_v;
            n_green = r_b_v;
            n_blue  = r_b_v;
        end else begin
            case (r_b_sector)
                SEC_RED_GREEN: begin
                    n_red = r_b_v; n_green = r_b_t; n_blue = r_b_p;
                end
                SEC_GREEN_RED: begin
                    n_red = r_b_q; n_green = r_b_v; n_blue = r_b_p;
                end
                SEC_GREEN_BLUE: begin
                    n_red = r_b_p; n_green = r_b_v; n_blue = r_b_t;
                end
                SEC_BLUE_GREEN: begin
                    n_red = r_b_p; n_green = r_b_q; n_blue = r_b_v;
                end
                SEC_BLUE_RED: begin
                    n_red = r_b_t; n_green = r_b_p; n_blue = r_b_v;
                end
                default: begin
                    n_red = r_b_v; n_green = r_b_p; n_blue = r_b_q;
                end
            endcase
        end
    end

    logic            r_strobe;
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_a_valid <= div_valid;
            r_b_valid <= r_a_valid;
            r_strobe  <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_strobe = r_strobe;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;

    a_strobe_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, PIPE_LAT))
        else $error("result strobe without a matching item");

    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_sat == '0) |=> (o_red == o_green && o_green == o_blue))
        else $error("zero saturation item is not gray");

    a_p_below_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> r_a_p <= r_a_v)
        else $error("p channel above brightness");

endmodule
`default_nettype wire

@@ rtl/core/phr_hue_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module phr_hue_div
    import phr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic [CNT_W-1:0] i_n,
    output logic                  o_valid,
    output t_hue                  o_hue
);

    // index mod n, one quotient bit per stage
    logic             r_mv   [0:MOD_STEPS];
    logic [IDX_W-1:0] r_midx [0:MOD_STEPS];
    logic [CNT_W-1:0] r_mrem [0:MOD_STEPS];

    // 6 * m * ONE / n, one quotient bit per stage
    logic                 r_hv   [0:HUE_STEPS];
    logic                 r_hodd [0:HUE_STEPS];
    logic [REM_W-1:0]     r_hrem [0:HUE_STEPS];
    logic [HUE_STEPS-1:0] r_hq   [0:HUE_STEPS];

    logic [REM_W-1:0] n_wide;
    assign n_wide = REM_W'(i_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv[0] <= 1'b0;
            r_hv[0] <= 1'b0;
        end else begin
            r_mv[0] <= i_valid;
            r_hv[0] <= r_mv[MOD_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_midx[0] <= i_idx;
        r_mrem[0] <= '0;
        r_hodd[0] <= r_midx[MOD_STEPS][0];
        r_hrem[0] <= REM_W'(r_mrem[MOD_STEPS]) * REM_W'(6);
        r_hq[0]   <= '0;
    end

    for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
        logic [CNT_W:0] trial;
        logic           ge;
        assign trial = {r_mrem[k], r_midx[k][IDX_W-1-k]};
        assign ge    = trial >= {1'b0, i_n};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv[k+1] <= 1'b0;
            end else begin
                r_mv[k+1] <= r_mv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_midx[k+1] <= r_midx[k];
            r_mrem[k+1] <= ge ? CNT_W'(trial - {1'b0, i_n}) : trial[CNT_W-1:0];
        end
    end

    for (genvar j = 0; j < HUE_STEPS; j++) begin : g_hue
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] divisor;
        logic             ge;
        if (j < SECT_BITS) begin : g_int
            assign trial   = r_hrem[j];
            assign divisor = n_wide << (SECT_BITS - 1 - j);
        end else begin : g_frac
            assign trial   = r_hrem[j] << 1;
            assign divisor = n_wide;
        end
        assign ge = trial >= divisor;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hv[j+1] <= 1'b0;
            end else begin
                r_hv[j+1] <= r_hv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_hodd[j+1] <= r_hodd[j];
            r_hrem[j+1] <= ge ? trial - divisor : trial;
            r_hq[j+1]   <= {r_hq[j][HUE_STEPS-2:0], ge};
        end
    end

    assign o_valid       = r_hv[HUE_STEPS];
    assign o_hue.odd     = r_hodd[HUE_STEPS];
    assign o_hue.sector  = r_hq[HUE_STEPS][HUE_STEPS-1:FRAC_BITS];
    assign o_hue.frac    = r_hq[HUE_STEPS][FRAC_BITS-1:0];

    a_mod_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hv[0] |-> r_hrem[0] < (n_wide * REM_W'(6)))
        else $error("index remainder not below palette size");

    a_rem_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_hrem[HUE_STEPS] < n_wide)
        else $error("hue remainder not below palette size");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hue.sector <= 3'd5)
        else $error("hue sector out of range");

endmodule
`default_nettype wire
